@@ rtl/dkp_pkg.sv @@
// Shared types, register indexes, key masks and command codes for the
// debounced key press controller. No dependencies.
package dkp_pkg;

  localparam int unsigned KEY_COUNT = 4;
  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned DATA_W    = 32;

  // register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_SAMPLE_PERIOD   = 3'd0;
  localparam logic [2:0] REG_WINDOW_SAMPLES  = 3'd1;
  localparam logic [2:0] REG_MATCH_THRESHOLD = 3'd2;
  localparam logic [2:0] REG_SHORT_BOUND     = 3'd3;
  localparam logic [2:0] REG_LONG_BOUND      = 3'd4;
  localparam logic [2:0] REG_VOLUME_STEP     = 3'd5;
  localparam logic [2:0] REG_VIBRATE_TICKS   = 3'd6;

  // reset values
  localparam logic [7:0]  RST_SAMPLE_PERIOD   = 8'd3;
  localparam logic [3:0]  RST_WINDOW_SAMPLES  = 4'd15;
  localparam logic [3:0]  RST_MATCH_THRESHOLD = 4'd8;
  localparam logic [3:0]  RST_SHORT_BOUND     = 4'd8;
  localparam logic [3:0]  RST_LONG_BOUND      = 4'd12;
  localparam logic [7:0]  RST_VOLUME_STEP     = 8'd4;
  localparam logic [15:0] RST_VIBRATE_TICKS   = 16'd200;

  // single-key window values
  localparam logic [KEY_COUNT-1:0] KEY_RECORD = 4'b0001;
  localparam logic [KEY_COUNT-1:0] KEY_PAUSE  = 4'b0010;
  localparam logic [KEY_COUNT-1:0] KEY_NEXT   = 4'b0100;
  localparam logic [KEY_COUNT-1:0] KEY_PREV   = 4'b1000;

  localparam logic [3:0] HOLD_MAX        = 4'd15;
  localparam logic [3:0] HOLD_AFTER_STEP = 4'd5;
  localparam logic [3:0] COUNT_MAX       = 4'd15;
  localparam logic [7:0] VOLUME_MAX      = 8'd255;

  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_RECORD = 3'd1,
    CMD_STOP   = 3'd2,
    CMD_PAUSE  = 3'd3,
    CMD_NEXT   = 3'd4,
    CMD_PREV   = 3'd5,
    CMD_VOLUME = 3'd6
  } cmd_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_RECORD = 5'b00010,
    ST_PAUSE  = 5'b00100,
    ST_NEXT   = 5'b01000,
    ST_PREV   = 5'b10000
  } key_state_t;

  typedef struct packed {
    logic [7:0]  sample_period;
    logic [3:0]  window_samples;
    logic [3:0]  match_threshold;
    logic [3:0]  short_bound;
    logic [3:0]  long_bound;
    logic [7:0]  volume_step;
    logic [15:0] vibrate_ticks;
  } cfg_t;

  // debounce window result handed to the key machine
  typedef struct packed {
    logic                 accept;
    logic [KEY_COUNT-1:0] value;
  } win_t;

endpackage

@@ rtl/dkp_cfg_regs.sv @@
// APB-style configuration register file for the key press controller.
// Depends on dkp_pkg.
module dkp_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dkp_pkg::ADDR_W-1:0]  paddr,
  input  logic [dkp_pkg::DATA_W-1:0]  pwdata,
  output logic [dkp_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output dkp_pkg::cfg_t               cfg
);

  dkp_pkg::cfg_t cfg_r;
  logic [2:0]    idx;
  logic          wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_period   <= dkp_pkg::RST_SAMPLE_PERIOD;
      cfg_r.window_samples  <= dkp_pkg::RST_WINDOW_SAMPLES;
      cfg_r.match_threshold <= dkp_pkg::RST_MATCH_THRESHOLD;
      cfg_r.short_bound     <= dkp_pkg::RST_SHORT_BOUND;
      cfg_r.long_bound      <= dkp_pkg::RST_LONG_BOUND;
      cfg_r.volume_step     <= dkp_pkg::RST_VOLUME_STEP;
      cfg_r.vibrate_ticks   <= dkp_pkg::RST_VIBRATE_TICKS;
    end else if (wr_en) begin
      unique case (idx)
        dkp_pkg::REG_SAMPLE_PERIOD:   cfg_r.sample_period   <= pwdata[7:0];
        dkp_pkg::REG_WINDOW_SAMPLES:  cfg_r.window_samples  <= pwdata[3:0];
        dkp_pkg::REG_MATCH_THRESHOLD: cfg_r.match_threshold <= pwdata[3:0];
        dkp_pkg::REG_SHORT_BOUND:     cfg_r.short_bound     <= pwdata[3:0];
        dkp_pkg::REG_LONG_BOUND:      cfg_r.long_bound      <= pwdata[3:0];
        dkp_pkg::REG_VOLUME_STEP:     cfg_r.volume_step     <= pwdata[7:0];
        dkp_pkg::REG_VIBRATE_TICKS:   cfg_r.vibrate_ticks   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      dkp_pkg::REG_SAMPLE_PERIOD:   prdata = {24'd0, cfg_r.sample_period};
      dkp_pkg::REG_WINDOW_SAMPLES:  prdata = {28'd0, cfg_r.window_samples};
      dkp_pkg::REG_MATCH_THRESHOLD: prdata = {28'd0, cfg_r.match_threshold};
      dkp_pkg::REG_SHORT_BOUND:     prdata = {28'd0, cfg_r.short_bound};
      dkp_pkg::REG_LONG_BOUND:      prdata = {28'd0, cfg_r.long_bound};
      dkp_pkg::REG_VOLUME_STEP:     prdata = {24'd0, cfg_r.volume_step};
      dkp_pkg::REG_VIBRATE_TICKS:   prdata = {16'd0, cfg_r.vibrate_ticks};
      default:                      prdata = '0;
    endcase
  end

endmodule

@@ rtl/dkp_debounce.sv @@
// Key sampler and debounce window: decides once per tick whether a window
// closes and is accepted. Depends on dkp_pkg.
module dkp_debounce (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           fire,
  input  logic [dkp_pkg::KEY_COUNT-1:0]  keys,
  input  dkp_pkg::cfg_t                  cfg,
  output dkp_pkg::win_t                  win
);

  logic [7:0]                    tick_r, tick_nxt, tick_inc, period;
  logic [3:0]                    wc_r, wc_nxt, wc_inc, wsamp;
  logic [3:0]                    mc_r, mc_nxt, mc_inc;
  logic [dkp_pkg::KEY_COUNT-1:0] wv_r, wv_nxt;
  logic                          samp, close;

  always_comb begin
    period = (cfg.sample_period == 8'd0) ? 8'd1 : cfg.sample_period;
    wsamp  = (cfg.window_samples == 4'd0) ? 4'd1 : cfg.window_samples;

    tick_inc = tick_r + 8'd1;
    samp     = (tick_inc >= period);
    tick_nxt = samp ? 8'd0 : tick_inc;

    wv_nxt = (samp && wc_r == 4'd0) ? keys : wv_r;
    mc_inc = (samp && keys == wv_nxt && mc_r < dkp_pkg::COUNT_MAX) ? mc_r + 4'd1 : mc_r;
    wc_inc = (samp && wc_r < dkp_pkg::COUNT_MAX) ? wc_r + 4'd1 : wc_r;

    // a closing window clears both counts, accepted or not
    close  = (wc_inc >= wsamp);
    wc_nxt = close ? 4'd0 : wc_inc;
    mc_nxt = close ? 4'd0 : mc_inc;

    win.accept = close && (mc_inc > cfg.match_threshold);
    win.value  = wv_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
      wc_r   <= '0;
      mc_r   <= '0;
      wv_r   <= '0;
    end else if (fire) begin
      tick_r <= tick_nxt;
      wc_r   <= wc_nxt;
      mc_r   <= mc_nxt;
      wv_r   <= wv_nxt;
    end
  end

endmodule

@@ rtl/dkp_key_fsm.sv @@
// Five-state key machine with hold counters, volume stepping and the
// vibration motor pulse timer. Depends on dkp_pkg.
module dkp_key_fsm (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           fire,
  input  dkp_pkg::win_t                  win,
  input  logic [7:0]                     cur_volume,
  input  dkp_pkg::cfg_t                  cfg,
  output dkp_pkg::cmd_t                  cmd,
  output logic [7:0]                     new_volume,
  output logic                           motor_on,
  output logic [dkp_pkg::KEY_COUNT-1:0]  debounced_keys
);

  dkp_pkg::key_state_t           st_r, st_nxt;
  logic [3:0]                    nh_r, nh_nxt, ph_r, ph_nxt;
  logic [dkp_pkg::KEY_COUNT-1:0] prev_r, prev_nxt, v;
  logic                          va_r, va_nxt, va_mid;
  logic [15:0]                   el_r, el_nxt, el_mid;
  logic [8:0]                    vol_sum;
  logic [7:0]                    vol_up, vol_down;

  always_comb begin
    vol_sum  = {1'b0, cur_volume} + {1'b0, cfg.volume_step};
    vol_up   = vol_sum[8] ? dkp_pkg::VOLUME_MAX : vol_sum[7:0];
    vol_down = (cur_volume < cfg.volume_step) ? 8'd0 : cur_volume - cfg.volume_step;
  end

  always_comb begin
    v        = win.value;
    st_nxt   = st_r;
    nh_nxt   = nh_r;
    ph_nxt   = ph_r;
    prev_nxt = prev_r;
    cmd      = dkp_pkg::CMD_NONE;
    new_volume = 8'd0;

    // motor timer runs before the window is handled
    va_mid = va_r && (el_r < cfg.vibrate_ticks);
    el_mid = (va_r && el_r < cfg.vibrate_ticks) ? el_r + 16'd1 : el_r;
    va_nxt = va_mid;
    el_nxt = el_mid;

    if (win.accept) begin
      if (v != prev_r) begin
        prev_nxt = v;
        if (v != '0 && !va_mid) begin
          va_nxt = 1'b1;
          el_nxt = 16'd0;
        end
      end
      unique case (st_r)
        dkp_pkg::ST_IDLE: begin
          priority if (v == dkp_pkg::KEY_RECORD) begin
            st_nxt = dkp_pkg::ST_RECORD;
            cmd    = dkp_pkg::CMD_RECORD;
          end else if (v == dkp_pkg::KEY_PAUSE) begin
            st_nxt = dkp_pkg::ST_PAUSE;
          end else if (v == dkp_pkg::KEY_NEXT) begin
            st_nxt = dkp_pkg::ST_NEXT;
            if (nh_r < dkp_pkg::HOLD_MAX) nh_nxt = nh_r + 4'd1;
          end else if (v == dkp_pkg::KEY_PREV) begin
            st_nxt = dkp_pkg::ST_PREV;
            if (ph_r < dkp_pkg::HOLD_MAX) ph_nxt = ph_r + 4'd1;
          end else begin
          end
        end
        dkp_pkg::ST_RECORD: begin
          if ((v & dkp_pkg::KEY_RECORD) == '0) begin
            st_nxt = dkp_pkg::ST_IDLE;
            cmd    = dkp_pkg::CMD_STOP;
          end
        end
        dkp_pkg::ST_PAUSE: begin
          if ((v & dkp_pkg::KEY_PAUSE) == '0) begin
            st_nxt = dkp_pkg::ST_IDLE;
            cmd    = dkp_pkg::CMD_PAUSE;
          end
        end
        dkp_pkg::ST_NEXT: begin
          if ((v & dkp_pkg::KEY_NEXT) == '0) begin
            st_nxt = dkp_pkg::ST_IDLE;
            nh_nxt = 4'd0;
            if (nh_r != 4'd0 && nh_r < cfg.short_bound) cmd = dkp_pkg::CMD_NEXT;
          end else if (nh_r > cfg.long_bound) begin
            cmd        = dkp_pkg::CMD_VOLUME;
            new_volume = vol_up;
            nh_nxt     = dkp_pkg::HOLD_AFTER_STEP;
          end else if (nh_r < dkp_pkg::HOLD_MAX) begin
            nh_nxt = nh_r + 4'd1;
          end
        end
        dkp_pkg::ST_PREV: begin
          if ((v & dkp_pkg::KEY_PREV) == '0) begin
            st_nxt = dkp_pkg::ST_IDLE;
            ph_nxt = 4'd0;
            if (ph_r != 4'd0 && ph_r < cfg.short_bound) cmd = dkp_pkg::CMD_PREV;
          end else if (ph_r > cfg.long_bound) begin
            cmd        = dkp_pkg::CMD_VOLUME;
            new_volume = vol_down;
            ph_nxt     = dkp_pkg::HOLD_AFTER_STEP;
          end else if (ph_r < dkp_pkg::HOLD_MAX) begin
            ph_nxt = ph_r + 4'd1;
          end
        end
        default: st_nxt = dkp_pkg::ST_IDLE;
      endcase
    end

    motor_on       = va_r;
    debounced_keys = prev_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= dkp_pkg::ST_IDLE;
      nh_r   <= '0;
      ph_r   <= '0;
      prev_r <= '0;
      va_r   <= 1'b0;
      el_r   <= '0;
    end else if (fire) begin
      st_r   <= st_nxt;
      nh_r   <= nh_nxt;
      ph_r   <= ph_nxt;
      prev_r <= prev_nxt;
      va_r   <= va_nxt;
      el_r   <= el_nxt;
    end
  end

endmodule

@@ rtl/debounced_key_press_controller_top.sv @@
// Top level of the debounced key press controller: config regs, debounce
// window, key machine and result register. Depends on dkp_pkg and the dkp_ modules.
//
// Usage:
// - Input channel (in_valid/in_ready): one request per millisecond tick,
//   carrying the four key levels (bit i = key i+1, 1 = pressed) and the
//   player's present volume.
// - Result channel (out_valid/out_ready): exactly one result per input
//   request: command, new_volume (only nonzero with set volume), motor drive
//   sampled at the start of the tick, and the last accepted debounced keys.
// - A request accepted at edge N shows its result after edge N. Throughput
//   is one request per cycle while out_ready is high; the whole tick is one
//   pass of short logic from the state registers into the result register.
// - The result register doubles as the slot between the two sides: in_ready
//   is high while the slot is empty or being taken in the same cycle, so a
//   stalled receiver holds the result and back-pressures the input.
// - Reset (rst_n low, synchronous) empties the result slot, clears all tick,
//   window, hold and motor state to zero, puts the key machine in idle and
//   loads the register defaults.
// - Configuration: APB-style, register i at byte 4*i, pready always high;
//   write only while no request is in flight.
module debounced_key_press_controller_top (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dkp_pkg::ADDR_W-1:0]     paddr,
  input  logic [dkp_pkg::DATA_W-1:0]     pwdata,
  output logic [dkp_pkg::DATA_W-1:0]     prdata,
  output logic                           pready,
  // input channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [dkp_pkg::KEY_COUNT-1:0]  in_key_levels,
  input  logic [7:0]                     in_current_volume,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     out_command,
  output logic [7:0]                     out_new_volume,
  output logic                           out_motor_on,
  output logic [dkp_pkg::KEY_COUNT-1:0]  out_debounced_keys
);

  dkp_pkg::cfg_t                 cfg;
  dkp_pkg::win_t                 win;
  dkp_pkg::cmd_t                 cmd;
  logic [7:0]                    new_vol;
  logic                          motor;
  logic [dkp_pkg::KEY_COUNT-1:0] dkeys;
  logic                          in_fire;

  logic                          out_valid_r;
  logic [2:0]                    cmd_r;
  logic [7:0]                    vol_r;
  logic                          motor_r;
  logic [dkp_pkg::KEY_COUNT-1:0] keys_r;

  // slot frees up when empty or drained this cycle
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  dkp_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dkp_debounce u_deb (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (in_fire),
    .keys  (in_key_levels),
    .cfg   (cfg),
    .win   (win)
  );

  dkp_key_fsm u_fsm (
    .clk            (clk),
    .rst_n          (rst_n),
    .fire           (in_fire),
    .win            (win),
    .cur_volume     (in_current_volume),
    .cfg            (cfg),
    .cmd            (cmd),
    .new_volume     (new_vol),
    .motor_on       (motor),
    .debounced_keys (dkeys)
  );

  // result slot: valid is control, payload loads without reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r   <= cmd;
      vol_r   <= new_vol;
      motor_r <= motor;
      keys_r  <= dkeys;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_command        = cmd_r;
  assign out_new_volume     = vol_r;
  assign out_motor_on       = motor_r;
  assign out_debounced_keys = keys_r;

  // new_volume is only carried with a set volume command
  a_vol_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_command != dkp_pkg::CMD_VOLUME) |-> (out_new_volume == 8'd0))
    else $error("new_volume nonzero without set volume command");

  // command codes stay within the defined set
  a_cmd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_command <= dkp_pkg::CMD_VOLUME))
    else $error("undefined command code");

  // every accepted request leaves a result in the slot
  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted request produced no result");

  // input is only held off by a full, stalled result slot
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid_r && !out_ready))
    else $error("input stalled with free result slot");

endmodule
